FILE: rtl/bbe_pkg.sv
package bbe_pkg;

	localparam int CH_W  = 8;
	localparam int PIX_W = 3 * CH_W;
	localparam int FW_W  = 11;
	localparam int FH_W  = 12;
	localparam int CFG_W = 12;
	localparam int SUM_W = 12;
	localparam int X_W   = 13;
	localparam int REC_W = 16;

	typedef logic [0:0] reg_idx_t;

	localparam reg_idx_t REG_WIDTH  = 1'b0;
	localparam reg_idx_t REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [8:0] incl;
		logic [3:0] n;
	} lane_ctl_t;

	function automatic logic [REC_W-1:0] bbe_recip(input logic [3:0] n);
		logic [REC_W-1:0] m;
		case (n)
			4'd1: m = 16'd32768;
			4'd2: m = 16'd16384;
			4'd3: m = 16'd10922;
			4'd4: m = 16'd8192;
			4'd6: m = 16'd5461;
			4'd9: m = 16'd3640;
			default: m = 16'd0;
		endcase
		return m;
	endfunction

endpackage

FILE: rtl/bbe_if.sv
interface bbe_in_if import bbe_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] in_red;
	logic [CH_W-1:0] in_green;
	logic [CH_W-1:0] in_blue;

	modport source (output valid, output in_red, output in_green, output in_blue,
		input ready);
	modport sink (input valid, input in_red, input in_green, input in_blue,
		output ready);
endinterface

interface bbe_out_if import bbe_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] out_red;
	logic [CH_W-1:0] out_green;
	logic [CH_W-1:0] out_blue;
	logic            run_last;
	logic            frame_done;

	modport source (output valid, output out_red, output out_green, output out_blue,
		output run_last, output frame_done, input ready);
	modport sink (input valid, input out_red, input out_green, input out_blue,
		input run_last, input frame_done, output ready);
endinterface

FILE: rtl/bbe_lane.sv
module bbe_lane import bbe_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  lane_ctl_t            ctl,
	input  logic [8:0][CH_W-1:0] pix,
	output logic [CH_W-1:0]      q
);

	logic [SUM_W-1:0]         sum;
	logic [X_W-1:0]           x_s3;
	logic [3:0]               n_s3;
	logic [X_W+REC_W-1:0]     prod;
	logic [SUM_W-1:0]         q0_s4;
	logic [X_W-1:0]           x_s4;
	logic [4:0]               d_s4;
	logic [SUM_W+4:0]         qd;
	logic [X_W-1:0]           rem;
	logic [SUM_W-1:0]         qf;

	always_comb begin
		sum = '0;
		for (int i = 0; i < 9; i++) begin
			if (ctl.incl[i]) begin
				sum = sum + SUM_W'(pix[i]);
			end
		end
	end

	assign prod = (X_W+REC_W)'(x_s3) * (X_W+REC_W)'(bbe_recip(n_s3));

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3  <= {sum, 1'b0} + X_W'(ctl.n);
			n_s3  <= ctl.n;
			q0_s4 <= prod[REC_W+SUM_W-1:REC_W];
			x_s4  <= x_s3;
			d_s4  <= {n_s3, 1'b0};
		end
	end

	always_comb begin
		qd  = {5'b0, q0_s4} * {12'b0, d_s4};
		rem = x_s4 - qd[X_W-1:0];
		qf  = (rem >= X_W'(d_s4)) ? q0_s4 + 12'd1 : q0_s4;
		q   = (qf > 12'd255) ? 8'hFF : qf[CH_W-1:0];
	end

endmodule

FILE: rtl/box_blur_3x3_edge_aware.sv
// An input beat passes stage 1, the window, lane stages s3 and s4 and the output register.
// Throughput: one pixel per cycle while the output accepts and each pixel gives at most
// one result; a pixel in the last column or last row holds the input while its extra
// results (up to three) go out; the result sequencer issues one result a cycle to the lanes.
// Reset clears the pipeline, window and position, and sets width 640 and height 480.
// The line buffers are not cleared; there is no clearing pass.
module box_blur_3x3_edge_aware import bbe_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  reg_idx_t         wr_index,
	input  logic [CFG_W-1:0] wr_data,
	bbe_in_if.sink           pix_in,
	bbe_out_if.source        pix_out
);

	localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RES_A = 0;
	localparam int RES_B = 1;
	localparam int RES_C = 2;
	localparam int RES_D = 3;

	logic [FW_W-1:0] cfg_width_q;
	logic [FH_W-1:0] cfg_height_q;
	logic [AW-1:0]   col_q;
	logic [FH_W-1:0] row_q;
	logic [AW-1:0]   wm1;
	logic [FH_W-1:0] hm1;

	logic [PIX_W-1:0] older_mem [MAX_WIDTH];
	logic [PIX_W-1:0] recent_mem [MAX_WIDTH];
	logic [PIX_W-1:0] rd_old_q;
	logic [PIX_W-1:0] rd_rec_q;

	logic             acc;
	logic             s1_valid;
	logic             s1_go;
	logic [PIX_W-1:0] px_s1;
	logic [AW-1:0]    col_s1;
	logic [3:0]       mask_s1;
	logic [3:0]       pos_s1;
	logic             fwd_s1;
	logic [PIX_W-1:0] fwd_old_s1;
	logic [PIX_W-1:0] fwd_rec_s1;
	logic [PIX_W-1:0] old_v;
	logic [PIX_W-1:0] rec_v;
	logic             lastc;
	logic             lastr;
	logic [3:0]       pos_in;

	logic [2:0][2:0][PIX_W-1:0] win_q;

	logic [3:0] mask_s2;
	logic [3:0] mask_next;
	logic [3:0] pos_s2;
	logic       s2_free;
	logic       emit;
	logic       adv;
	logic       sel_a;
	logic       sel_b;
	logic       sel_c;
	logic       sel_d;
	logic [1:0] r0;
	logic [1:0] c0;
	logic [3:0] nr;
	logic [3:0] nc;
	lane_ctl_t  ctl;

	logic [8:0][CH_W-1:0] pr;
	logic [8:0][CH_W-1:0] pg;
	logic [8:0][CH_W-1:0] pb;
	logic [CH_W-1:0]      qr;
	logic [CH_W-1:0]      qg;
	logic [CH_W-1:0]      qb;

	logic v3_s3;
	logic last_s3;
	logic done_s3;
	logic v4_s4;
	logic last_s4;
	logic done_s4;
	logic            out_valid_q;
	logic [CH_W-1:0] out_red_q;
	logic [CH_W-1:0] out_green_q;
	logic [CH_W-1:0] out_blue_q;
	logic            out_last_q;
	logic            out_done_q;

	always_comb begin
		if (cfg_width_q == '0) begin
			wm1 = '0;
		end else if (32'(cfg_width_q) > MAX_WIDTH) begin
			wm1 = AW'(MAX_WIDTH - 1);
		end else begin
			wm1 = AW'(cfg_width_q - 11'd1);
		end
		hm1 = (cfg_height_q == '0) ? '0 : cfg_height_q - 12'd1;
	end

	assign adv     = !out_valid_q || pix_out.ready;
	assign emit    = adv && (mask_s2 != 4'd0);
	assign s2_free = (mask_s2 == 4'd0) || (adv && (mask_next == 4'd0));
	assign s1_go   = s1_valid && s2_free;
	assign pix_in.ready = !s1_valid || s1_go;
	assign acc     = pix_in.valid && pix_in.ready;

	assign lastc  = (col_q == wm1);
	assign lastr  = (row_q == hm1);
	assign pos_in = {row_q != '0, row_q >= 12'd2, col_q != '0, 32'(col_q) >= 2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q  <= FW_W'(640);
			cfg_height_q <= FH_W'(480);
			col_q        <= '0;
			row_q        <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_WIDTH:  cfg_width_q  <= wr_data[FW_W-1:0];
				REG_HEIGHT: cfg_height_q <= wr_data[FH_W-1:0];
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (lastc) begin
				col_q <= '0;
				row_q <= lastr ? '0 : row_q + 12'd1;
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	assign old_v = fwd_s1 ? fwd_old_s1 : rd_old_q;
	assign rec_v = fwd_s1 ? fwd_rec_s1 : rd_rec_q;

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_old_q <= older_mem[col_q];
			rd_rec_q <= recent_mem[col_q];
		end
		if (s1_go) begin
			older_mem[col_s1]  <= rec_v;
			recent_mem[col_s1] <= px_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			px_s1      <= {pix_in.in_red, pix_in.in_green, pix_in.in_blue};
			col_s1     <= col_q;
			pos_s1     <= pos_in;
			mask_s1    <= {lastr && lastc, lastr && pos_in[1], pos_in[3] && lastc,
				pos_in[3] && pos_in[1]};
			fwd_old_s1 <= rec_v;
			fwd_rec_s1 <= px_s1;
		end
		if (s1_go) begin
			pos_s2 <= pos_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			if (acc) begin
				s1_valid <= 1'b1;
				fwd_s1   <= s1_go && (col_s1 == col_q);
			end else if (s1_go) begin
				s1_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			mask_s2 <= '0;
		end else if (s1_go) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= old_v;
			win_q[1][2] <= rec_v;
			win_q[2][2] <= px_s1;
			mask_s2     <= mask_s1;
		end else if (emit) begin
			mask_s2 <= mask_next;
		end
	end

	assign mask_next = mask_s2 & (mask_s2 - 4'd1);

	always_comb begin
		sel_a = mask_s2[RES_A];
		sel_b = !mask_s2[RES_A] && mask_s2[RES_B];
		sel_c = !mask_s2[RES_A] && !mask_s2[RES_B] && mask_s2[RES_C];
		sel_d = !mask_s2[RES_A] && !mask_s2[RES_B] && !mask_s2[RES_C] && mask_s2[RES_D];
		if (sel_a || sel_b) begin
			r0 = pos_s2[2] ? 2'd0 : 2'd1;
		end else begin
			r0 = pos_s2[3] ? 2'd1 : 2'd2;
		end
		if (sel_a || sel_c) begin
			c0 = pos_s2[0] ? 2'd0 : 2'd1;
		end else begin
			c0 = pos_s2[1] ? 2'd1 : 2'd2;
		end
		nr = {2'b00, 2'd3 - r0};
		nc = {2'b00, 2'd3 - c0};
		ctl.n = nr * nc;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				ctl.incl[r*3+c] = (2'(r) >= r0) && (2'(c) >= c0);
				pr[r*3+c] = win_q[r][c][3*CH_W-1:2*CH_W];
				pg[r*3+c] = win_q[r][c][2*CH_W-1:CH_W];
				pb[r*3+c] = win_q[r][c][CH_W-1:0];
			end
		end
	end

	bbe_lane u_lane_red (.clk(clk), .en(adv), .ctl(ctl), .pix(pr), .q(qr));
	bbe_lane u_lane_green (.clk(clk), .en(adv), .ctl(ctl), .pix(pg), .q(qg));
	bbe_lane u_lane_blue (.clk(clk), .en(adv), .ctl(ctl), .pix(pb), .q(qb));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_s3       <= 1'b0;
			v4_s4       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v3_s3       <= emit;
			v4_s4       <= v3_s3;
			out_valid_q <= v4_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s3 <= (mask_next == 4'd0);
			done_s3 <= sel_d;
			last_s4 <= last_s3;
			done_s4 <= done_s3;
			if (v4_s4) begin
				out_red_q   <= qr;
				out_green_q <= qg;
				out_blue_q  <= qb;
				out_last_q  <= last_s4;
				out_done_q  <= done_s4;
			end
		end
	end

	assign pix_out.valid      = out_valid_q;
	assign pix_out.out_red    = out_red_q;
	assign pix_out.out_green  = out_green_q;
	assign pix_out.out_blue   = out_blue_q;
	assign pix_out.run_last   = out_last_q;
	assign pix_out.frame_done = out_done_q;

endmodule

FILE: rtl/bbe_checker.sv
module bbe_checker import bbe_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            out_valid,
	input logic            out_ready,
	input logic [CH_W-1:0] out_red,
	input logic [CH_W-1:0] out_green,
	input logic [CH_W-1:0] out_blue,
	input logic            run_last,
	input logic            frame_done
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
			&& $stable(out_blue) && $stable(run_last) && $stable(frame_done))
		else $error("result beat changed while stalled");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> run_last)
		else $error("frame end beat without last-of-run mark");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result beat offered during reset");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(arst_n, 1) && $past(arst_n, 2) && $past(arst_n, 3)
			&& $past(arst_n, 4))
		else $error("result beat sooner than the pipeline allows");

endmodule

bind box_blur_3x3_edge_aware bbe_checker u_bbe_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (pix_out.valid),
	.out_ready  (pix_out.ready),
	.out_red    (pix_out.out_red),
	.out_green  (pix_out.out_green),
	.out_blue   (pix_out.out_blue),
	.run_last   (pix_out.run_last),
	.frame_done (pix_out.frame_done)
);
